### rtl/dasub_pkg.sv
// -----------------------------------------------------------------------------
// dasub_pkg: shared definitions for the substring deletion block
// Default store depths, load operation codes and sequencer states.
// -----------------------------------------------------------------------------
package dasub_pkg;

  localparam int TEXT_DEPTH_DEF    = 64;
  localparam int PATTERN_DEPTH_DEF = 16;

  // load operation codes
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,     // loading words
    ST_CHK,      // decide: compare at pos, or start output
    ST_CMP_RD,   // read text[pos+k] and pattern[k]
    ST_CMP_EV,   // compare the read bytes
    ST_SH_CHK,   // shift loop test, read text[j]
    ST_SH_WR,    // write text[j-plen]
    ST_EM_RD,    // read text[pos] for output
    ST_EM_LD,    // load output register
    ST_EM_WAIT   // hold result until taken
  } dasub_state_t;

endpackage

### rtl/dasub_ram.sv
// -----------------------------------------------------------------------------
// dasub_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
module dasub_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/delete_all_substring_occurrences_top.sv
// -----------------------------------------------------------------------------
// delete_all_substring_occurrences_top: remove every occurrence of a pattern
// A pattern and then a text are loaded one word per cycle (in_operation 0 for
// pattern, 1 for text). The text word marked in_is_last starts the run: the
// text is scanned from its first position, each pattern match is cut out by
// shifting the tail left and re-checked at the same position, then the
// surviving bytes are sent one word each (out_last on the final one), or one
// word with out_empty set if nothing is left. Bytes that find their store full
// are dropped and out_overflow is raised on every word of that run. An empty
// pattern deletes nothing. The run is done by one sequencer sharing a single
// byte comparator and one read port on the text RAM: each scan position passes
// a check state, then a read and a compare state per pattern byte up to the
// first mismatch; a removal reads and writes each tail byte moved, then closes
// with a final check; output reads, loads and holds each byte until it is
// taken. in_stall is high from the final text word until the last result word
// is taken; after that all counts and the overflow flag are clear and a new
// run begins.
// -----------------------------------------------------------------------------
module delete_all_substring_occurrences_top #(
  parameter int TEXT_DEPTH    = dasub_pkg::TEXT_DEPTH_DEF,
  parameter int PATTERN_DEPTH = dasub_pkg::PATTERN_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // load channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_last,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_empty,
  output logic       out_overflow
);

  import dasub_pkg::*;

  // count widths hold the depth itself; address widths index the stores
  localparam int CW  = $clog2(TEXT_DEPTH + 1);
  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int SW  = ((CW > PCW) ? CW : PCW) + 1;  // room for pos + plen

  dasub_state_t   state_r, state_nxt;
  logic [CW-1:0]  tcnt_r, tcnt_nxt;     // text length
  logic [PCW-1:0] pcnt_r, pcnt_nxt;     // pattern length
  logic           ovf_r, ovf_nxt;       // a byte was dropped this run
  logic [CW-1:0]  pos_r, pos_nxt;       // scan position, also output index
  logic [PCW-1:0] k_r, k_nxt;           // pattern byte under compare
  logic [CW-1:0]  j_r, j_nxt;           // shift source index

  logic [7:0]     obyte_r, obyte_nxt;
  logic           olast_r, olast_nxt;
  logic           oempty_r, oempty_nxt;
  logic           oovf_r, oovf_nxt;
  logic           ovalid_r, ovalid_nxt;

  // RAM controls
  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [7:0]     t_wdata, t_rdata;
  logic           p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [7:0]     p_rdata;

  // shared arithmetic
  logic [SW-1:0]  end_pos;   // pos + plen
  logic [SW-1:0]  cmp_idx;   // pos + k
  logic [SW-1:0]  sh_dst;    // j - plen
  logic           in_acc;

  assign end_pos = SW'(pos_r) + SW'(pcnt_r);
  assign cmp_idx = SW'(pos_r) + SW'(k_r);
  assign sh_dst  = SW'(j_r) - SW'(pcnt_r);
  assign in_acc  = in_valid && !in_stall;

  dasub_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  dasub_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (in_data_byte),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tcnt_r   <= '0;
      pcnt_r   <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tcnt_r   <= tcnt_nxt;
      pcnt_r   <= pcnt_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    k_r      <= k_nxt;
    j_r      <= j_nxt;
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
    oovf_r   <= oovf_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    tcnt_nxt   = tcnt_r;
    pcnt_nxt   = pcnt_r;
    ovf_nxt    = ovf_r;
    pos_nxt    = pos_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    oovf_nxt   = oovf_r;
    ovalid_nxt = ovalid_r;
    t_we       = 1'b0;
    t_waddr    = tcnt_r[TAW-1:0];
    t_wdata    = in_data_byte;
    t_raddr    = pos_r[TAW-1:0];
    p_we       = 1'b0;
    p_waddr    = pcnt_r[PAW-1:0];
    p_raddr    = k_r[PAW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_PATTERN) begin
            if (pcnt_r < PCW'(PATTERN_DEPTH)) begin
              p_we     = 1'b1;
              pcnt_nxt = pcnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            if (tcnt_r < CW'(TEXT_DEPTH)) begin
              t_we     = 1'b1;
              tcnt_nxt = tcnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_is_last) begin
              pos_nxt   = '0;
              state_nxt = ST_CHK;
            end
          end
        end
      end

      ST_CHK: begin
        if (pcnt_r == '0 || end_pos > SW'(tcnt_r)) begin
          // scan done
          pos_nxt = '0;
          if (tcnt_r == '0) begin
            obyte_nxt  = '0;
            olast_nxt  = 1'b1;
            oempty_nxt = 1'b1;
            oovf_nxt   = ovf_r;
            ovalid_nxt = 1'b1;
            state_nxt  = ST_EM_WAIT;
          end else begin
            state_nxt = ST_EM_RD;
          end
        end else begin
          k_nxt     = '0;
          state_nxt = ST_CMP_RD;
        end
      end

      ST_CMP_RD: begin
        t_raddr   = cmp_idx[TAW-1:0];
        p_raddr   = k_r[PAW-1:0];
        state_nxt = ST_CMP_EV;
      end

      ST_CMP_EV: begin
        if (t_rdata != p_rdata) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_CHK;
        end else if (SW'(k_r) + SW'(1) == SW'(pcnt_r)) begin
          // full match: move the tail down over it
          j_nxt     = end_pos[CW-1:0];
          state_nxt = ST_SH_CHK;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_CMP_RD;
        end
      end

      ST_SH_CHK: begin
        t_raddr = j_r[TAW-1:0];
        if (j_r < tcnt_r) begin
          state_nxt = ST_SH_WR;
        end else begin
          tcnt_nxt  = CW'(SW'(tcnt_r) - SW'(pcnt_r));
          state_nxt = ST_CHK;
        end
      end

      ST_SH_WR: begin
        t_we      = 1'b1;
        t_waddr   = sh_dst[TAW-1:0];
        t_wdata   = t_rdata;
        j_nxt     = j_r + 1'b1;
        state_nxt = ST_SH_CHK;
      end

      ST_EM_RD: begin
        t_raddr   = pos_r[TAW-1:0];
        state_nxt = ST_EM_LD;
      end

      ST_EM_LD: begin
        obyte_nxt  = t_rdata;
        olast_nxt  = (SW'(pos_r) + SW'(1) == SW'(tcnt_r));
        oempty_nxt = 1'b0;
        oovf_nxt   = ovf_r;
        ovalid_nxt = 1'b1;
        state_nxt  = ST_EM_WAIT;
      end

      ST_EM_WAIT: begin
        if (!out_stall) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            // run finished: start a fresh one
            tcnt_nxt  = '0;
            pcnt_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ST_EM_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = ovalid_r;
  assign out_byte     = obyte_r;
  assign out_last     = olast_r;
  assign out_empty    = oempty_r;
  assign out_overflow = oovf_r;

endmodule

### rtl/dasub_checker.sv
// -----------------------------------------------------------------------------
// dasub_checker: port-level checks for the substring deletion block
// Watches both channels and flags protocol or sequencing slips.
// -----------------------------------------------------------------------------
module dasub_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_operation,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_empty,
  input logic       out_overflow
);

  import dasub_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_empty) && $stable(out_overflow))
    else $error("result word changed while stalled");

  // no loading while a result is pending
  a_no_load_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // empty marker is a single last word with a zero byte
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last && out_byte == 8'd0)
    else $error("malformed empty marker");

  // final text word closes the input
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_TEXT && in_is_last |=> in_stall)
    else $error("input not closed after final text word");

  // nothing follows the last result word
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid && !in_stall)
    else $error("activity after last result word");

endmodule

bind delete_all_substring_occurrences_top dasub_checker u_dasub_checker (.*);

### tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench: self-checking bench for delete_all_substring_occurrences_top
// Loads pattern/text runs through the load channel and predicts the text left
// after every pattern occurrence is cut out. Each result word is checked
// field by field against the oldest prediction. Both channels idle at random.
// -----------------------------------------------------------------------------
module testbench;
  import dasub_pkg::*;

  localparam int TXT_DEPTH = TEXT_DEPTH_DEF;
  localparam int PAT_DEPTH = PATTERN_DEPTH_DEF;
  localparam int RANDOM_WORDS = 200;
  localparam int TAIL_CYCLES = 200;

  typedef logic [7:0] byte_q [$];

  // one load word plus its pacing: idle cycles before it, and whether the
  // sender holds it back until every predicted result word has come out
  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } load_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       ovf;
  } result_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_operation = OP_PATTERN;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_empty;
  logic       out_overflow;

  delete_all_substring_occurrences_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_empty    (out_empty),
    .out_overflow (out_overflow)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of both stores, their fill counts and the
  // sticky overflow flag for the run in progress.
  // ---------------------------------------------------------------------------
  logic [7:0] txt_mem [TXT_DEPTH];
  logic [7:0] pat_mem [PAT_DEPTH];
  int         txt_len = 0;
  int         pat_len = 0;
  bit         ovf_seen = 1'b0;

  load_word_t   pending_words [$];   // stimulus not yet handed to the DUT
  result_word_t expected_words [$];  // predicted output, oldest first
  int           words_total = 0;
  int           words_taken = 0;
  int           mismatches = 0;

  // pacing knobs read by add_word while the stimulus is built
  bit no_gaps = 1'b0;
  bit drain_next = 1'b0;

  // Cut every pattern occurrence out of the text, scanning left to right.
  // After a cut the same position is checked again; the scan never backs up.
  function automatic void cut_pattern();
    int  p;
    int  k;
    bit  hit;
    if (pat_len == 0) return;  // empty pattern removes nothing
    p = 0;
    while (p + pat_len <= txt_len) begin
      hit = 1'b1;
      for (k = 0; k < pat_len; k++)
        if (txt_mem[p + k] != pat_mem[k]) hit = 1'b0;
      if (hit) begin
        for (k = p + pat_len; k < txt_len; k++)
          txt_mem[k - pat_len] = txt_mem[k];
        txt_len -= pat_len;
      end else begin
        p++;
      end
    end
  endfunction

  // Apply one accepted load word; a final text word queues the run's output.
  function automatic void predict_word(logic op, logic [7:0] data, logic last);
    result_word_t w;
    int           k;
    if (op == OP_PATTERN) begin
      // is_last means nothing on a pattern word
      if (pat_len < PAT_DEPTH) begin
        pat_mem[pat_len] = data;
        pat_len++;
      end else begin
        ovf_seen = 1'b1;
      end
      return;
    end
    // a dropped text word still closes the run when it is the last one
    if (txt_len < TXT_DEPTH) begin
      txt_mem[txt_len] = data;
      txt_len++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!last) return;
    cut_pattern();
    if (txt_len == 0) begin
      w = '{data: 8'h00, last: 1'b1, empty: 1'b1, ovf: ovf_seen};
      expected_words.push_back(w);
    end else begin
      for (k = 0; k < txt_len; k++) begin
        w = '{data: txt_mem[k], last: (k + 1 == txt_len), empty: 1'b0, ovf: ovf_seen};
        expected_words.push_back(w);
      end
    end
    txt_len = 0;
    pat_len = 0;
    ovf_seen = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(logic op, logic [7:0] data, logic last);
    load_word_t w;
    w.op = op;
    w.data = data;
    w.last = last;
    w.gap = no_gaps ? 0 : $urandom_range(0, 6);
    w.drain = drain_next;
    drain_next = 1'b0;
    pending_words.push_back(w);
    words_total++;
  endtask

  // pattern words first, then text words with is_last on the final one
  task automatic add_run(byte_q pat, byte_q txt);
    foreach (pat[i]) add_word(OP_PATTERN, pat[i], 1'b0);
    foreach (txt[i]) add_word(OP_TEXT, txt[i], i == txt.size() - 1);
  endtask

  // Text of about tlen bytes over a small alphabet, with whole copies of the
  // pattern mixed in so that matches, back-to-back hits and near misses occur.
  function automatic byte_q mix_text(byte_q pat, byte_q alpha, int tlen);
    byte_q txt;
    txt = {};
    while (txt.size() < tlen) begin
      if (pat.size() != 0 && $urandom_range(0, 2) == 0)
        txt = {txt, pat};
      else
        txt.push_back(alpha[$urandom_range(0, alpha.size() - 1)]);
    end
    return txt;
  endfunction

  function automatic byte_q pick_bytes(byte_q alpha, int n);
    byte_q q;
    q = {};
    repeat (n) q.push_back(alpha[$urandom_range(0, alpha.size() - 1)]);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed runs, then random runs; reset; wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    byte_q pat;
    byte_q txt;
    byte_q alpha;
    int    r;
    int    kind;
    int    n;

    // empty pattern, extreme byte values: text comes back unchanged
    pat = {};
    txt = {8'h00, 8'hFF};
    add_run(pat, txt);
    // is_last on a pattern word is ignored; the text is all pattern -> empty
    add_word(OP_PATTERN, 8'hAA, 1'b1);
    pat = {};
    txt = {8'hAA, 8'hAA, 8'hAA};
    add_run(pat, txt);
    // pattern longer than text: nothing cut
    pat = {8'h01, 8'h02, 8'h03};
    txt = {8'h01, 8'h02};
    add_run(pat, txt);
    // "aabb" minus "ab": the cut exposes a new "ab" left of the scan point
    pat = {8'h61, 8'h62};
    txt = {8'h61, 8'h61, 8'h62, 8'h62};
    add_run(pat, txt);

    // random runs; the first one waits until the directed output is out
    drain_next = 1'b1;
    r = 0;
    while (words_total < RANDOM_WORDS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (r != 0 && $urandom_range(0, 5) == 0) drain_next = 1'b1;
      alpha = {};
      repeat ($urandom_range(2, 3)) alpha.push_back(8'($urandom));
      if (r == 1) kind = 1;
      else if (r == 3) kind = 2;
      else kind = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 9) == 0) ? 1 : 3);
      case (kind)
        0: begin
          // noise: random ops, bytes and is_last, closed by a final text word
          n = $urandom_range(1, 8);
          repeat (n) add_word(1'($urandom_range(0, 1)), 8'($urandom),
                              1'($urandom_range(0, 1)));
          add_word(OP_TEXT, 8'($urandom), 1'b1);
        end
        1: begin
          // pattern store near full, full or overflowing
          pat = pick_bytes(alpha, (r == 1) ? PAT_DEPTH : $urandom_range(15, 18));
          txt = mix_text(pat, alpha, $urandom_range(16, 40));
          add_run(pat, txt);
        end
        2: begin
          // text store full and beyond
          pat = pick_bytes(alpha, $urandom_range(1, 2));
          txt = mix_text(pat, alpha, $urandom_range(TXT_DEPTH, TXT_DEPTH + 2));
          add_run(pat, txt);
        end
        default: begin
          n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
          pat = pick_bytes(alpha, n);
          txt = mix_text(pat, alpha, $urandom_range(1, 20));
          add_run(pat, txt);
        end
      endcase
      r++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // all words taken and all predicted output seen, then a quiet tail in
    // which any stray result word would still be caught
    while (words_taken != words_total || expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Load driver: a word stays on the port until taken. Between words it waits
  // the word's gap and, if asked, until the predicted output has drained.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  bit gap_armed = 1'b0;

  always @(posedge clk) begin : load_driver
    logic       vld;
    load_word_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      vld = in_valid;
      if (in_valid && !in_stall) begin
        predict_word(in_operation, in_data_byte, in_is_last);
        words_taken++;
        vld = 1'b0;
      end
      if (!vld && pending_words.size() != 0) begin
        if (!gap_armed) begin
          gap_left = pending_words[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_words[0].drain && expected_words.size() != 0)) begin
          cur = pending_words.pop_front();
          in_operation <= cur.op;
          in_data_byte <= cur.data;
          in_is_last <= cur.last;
          gap_armed = 1'b0;
          vld = 1'b1;
        end
      end
      in_valid <= vld;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each taken word, then stalls for a random number of
  // cycles; now and then switches between stalling and streaming stretches.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit stall_busy = 1'b1;

  always @(posedge clk) begin : result_monitor
    result_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: byte %0h last %0b empty %0b overflow %0b",
                 out_byte, out_last, out_empty, out_overflow);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            mismatches++;
          end
          if (out_empty !== want.empty) begin
            $error("out_empty: expected %0b, got %0b", want.empty, out_empty);
            mismatches++;
          end
          if (out_overflow !== want.ovf) begin
            $error("out_overflow: expected %0b, got %0b", want.ovf, out_overflow);
            mismatches++;
          end
        end
        if ($urandom_range(0, 19) == 0) stall_busy = !stall_busy;
        stall_left = stall_busy ? $urandom_range(0, 6) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $error("timeout: %0d of %0d words taken, %0d result words outstanding",
           words_taken, words_total, expected_words.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
